// ===== rtl/bnbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bnbc_pkg
// Shared types and constants of the two-class Bernoulli naive Bayes unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bnbc_pkg;

    localparam int unsigned FEATURES_DEF   = 32;
    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned IN_BITS        = 32;
    localparam int unsigned TALLY_BITS     = 16;
    localparam int unsigned MAN_BITS       = 32;
    localparam int unsigned EXP_BITS       = 12;
    localparam int unsigned IN_TDATA_BITS  = 32;
    localparam int unsigned OUT_TDATA_BITS = 56;

    localparam logic ACT_TRAIN    = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the accepted transaction
        logic train;      // apply the training update
        logic score_init; // start both scores with their prior totals
        logic score_step; // apply one feature factor or one other total
        logic finish;     // compare and update the tallies
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_classify;
        logic last_feature;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/bernoulli_naive_bayes_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// bernoulli_naive_bayes_classifier_unit
// Two-class Bernoulli naive Bayes engine: trains counts, classifies samples.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                         | tuser
// s_axis  | in  | features[31:0]                             | action, label
// m_axis  | out | pred, correct, correct_tot, classified_tot,| -
//         |     | class_one_tot, zero pad                    |
// A train transaction is decoded and applied to the counts; a classify
// transaction is sequenced by one pair of shared score multipliers
// stepping through each feature factor and each other-class total.
// One transaction is worked on at a time; the result register holds a
// result until taken, and a new input is taken meanwhile.
// Reset clears all counts and tallies at once.
`default_nettype none

module bernoulli_naive_bayes_classifier_unit #(
    parameter int unsigned FEATURES   = bnbc_pkg::FEATURES_DEF,
    parameter int unsigned COUNT_BITS = bnbc_pkg::COUNT_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [bnbc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata, // features
    input  wire  [1:0]                           s_axis_tuser, // action, label
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [bnbc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata  // predicted_class,
    // prediction_correct, correct_total, classified_total, class_one_total, pad
);
    import bnbc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_idle, w_fire, r_ovalid;
    logic w_pred, w_correct;
    logic [TALLY_BITS-1:0] w_tc, w_tn, w_t1;

    assign s_axis_tready = w_idle;
    assign w_fire = s_axis_tvalid && s_axis_tready;

    bnbc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_out_busy(r_ovalid && !m_axis_tready), .i_sts(w_sts),
        .o_idle(w_idle), .o_cmd(w_cmd)
    );

    bnbc_dp #(.FEATURES(FEATURES), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_action(s_axis_tuser[0]), .i_features(s_axis_tdata[IN_BITS-1:0]),
        .i_label(s_axis_tuser[1]), .o_sts(w_sts),
        .o_pred(w_pred), .o_correct(w_correct), .o_correct_total(w_tc),
        .o_classified_total(w_tn), .o_class_one_total(w_t1)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_ovalid <= 1'b0;
        else if (w_cmd.finish) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b0, w_t1, w_tn, w_tc, w_correct, w_pred};

`ifndef NO_ASSERTIONS
    // a result is only raised by the finish command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.finish))
        else $error("result without finish");
    // a stalled result keeps its tallies
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    // finish never issued while a result is stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> !(r_ovalid && !m_axis_tready))
        else $error("overwrite of pending result");
`endif

endmodule

`default_nettype wire

// ===== rtl/bnbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bnbc_ctrl
// Controller: sequences training, per-feature scoring and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bnbc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_fire,
    input  wire                 i_out_busy,
    input  bnbc_pkg::t_sts      i_sts,
    output logic                o_idle,
    output bnbc_pkg::t_cmd      o_cmd
);
    import bnbc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_INIT   = 5'b00100,
        ST_SCORE  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_fire) n_state = ST_DECODE;
            ST_DECODE: n_state = i_sts.is_classify ? ST_INIT : ST_IDLE;
            ST_INIT:   n_state = ST_SCORE;
            ST_SCORE:  if (i_sts.last_feature) n_state = ST_FINISH;
            ST_FINISH: if (!i_out_busy) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // command decode
    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = i_in_fire;
        o_cmd.train      = (r_state == ST_DECODE) && !i_sts.is_classify;
        o_cmd.score_init = (r_state == ST_INIT);
        o_cmd.score_step = (r_state == ST_SCORE);
        o_cmd.finish     = (r_state == ST_FINISH) && !i_out_busy;
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/bnbc_dp.sv =====
// ----------------------------------------------------------------------------
// bnbc_dp
// Datapath: class counts, two pseudo-float scores and the running tallies.
// ----------------------------------------------------------------------------
`default_nettype none

module bnbc_dp #(
    parameter int unsigned FEATURES   = bnbc_pkg::FEATURES_DEF,
    parameter int unsigned COUNT_BITS = bnbc_pkg::COUNT_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  bnbc_pkg::t_cmd                      i_cmd,
    input  wire                                 i_action,
    input  wire  [bnbc_pkg::IN_BITS-1:0]        i_features,
    input  wire                                 i_label,
    output bnbc_pkg::t_sts                      o_sts,
    output logic                                o_pred,
    output logic                                o_correct,
    output logic [bnbc_pkg::TALLY_BITS-1:0]     o_correct_total,
    output logic [bnbc_pkg::TALLY_BITS-1:0]     o_classified_total,
    output logic [bnbc_pkg::TALLY_BITS-1:0]     o_class_one_total
);
    import bnbc_pkg::*;

    localparam int unsigned IDX_BITS = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int unsigned FIDX_BITS = $clog2(IN_BITS);
    localparam int unsigned PROD_BITS = MAN_BITS + COUNT_BITS;
    localparam int unsigned SH_BITS = $clog2(PROD_BITS + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TALLY_BITS-1:0] TAL_MAX = {TALLY_BITS{1'b1}};
    localparam logic [EXP_BITS-1:0] EXP_MAX = {EXP_BITS{1'b1}};
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(FEATURES - 1);

    logic [COUNT_BITS-1:0] r_cnt1 [FEATURES];
    logic [COUNT_BITS-1:0] r_cnt0 [FEATURES];
    logic [COUNT_BITS-1:0] r_n1, r_n0;
    logic [TALLY_BITS-1:0] r_tal_c, r_tal_n, r_tal_1;
    logic                  r_action, r_label;
    logic [IN_BITS-1:0]    r_feat;
    logic [IDX_BITS-1:0]   r_idx;
    logic                  r_pred, r_correct;

    // scores: zero flag, mantissa, exponent; a factor phase and an other-total phase per feature
    logic                  r_z1, r_z0;
    logic [MAN_BITS-1:0]   r_m1, r_m0;
    logic [EXP_BITS-1:0]   r_e1, r_e0;
    logic                  r_phase; // 0: feature factor, 1: other total

    function automatic logic [MAN_BITS+EXP_BITS:0] pf_mul(
        input logic z, input logic [MAN_BITS-1:0] m, input logic [EXP_BITS-1:0] e,
        input logic [COUNT_BITS-1:0] f);
        logic [PROD_BITS-1:0] p;
        logic [SH_BITS-1:0]   s;
        logic [EXP_BITS:0]    ex;
        logic [MAN_BITS-1:0]  mo;
        p = PROD_BITS'(m) * PROD_BITS'(f);
        s = '0;
        for (int k = PROD_BITS - 1; k >= MAN_BITS; k--) begin
            if (p[k] && s == '0) s = SH_BITS'(k - MAN_BITS + 1);
        end
        mo = MAN_BITS'(p >> s);
        ex = {1'b0, e} + (EXP_BITS+1)'(s);
        if (ex > {1'b0, EXP_MAX}) ex = {1'b0, EXP_MAX};
        if (z)            pf_mul = {1'b1, m, e};
        else if (f == '0) pf_mul = {1'b1, m, e};
        else              pf_mul = {1'b0, mo, ex[EXP_BITS-1:0]};
    endfunction

    function automatic logic pf_gt(
        input logic za, input logic [MAN_BITS-1:0] ma, input logic [EXP_BITS-1:0] ea,
        input logic zb, input logic [MAN_BITS-1:0] mb, input logic [EXP_BITS-1:0] eb);
        if (za)            pf_gt = 1'b0;
        else if (zb)       pf_gt = 1'b1;
        else if (ea != eb) pf_gt = ea > eb;
        else               pf_gt = ma > mb;
    endfunction

    // feature factors of the current index
    logic                  w_x;
    logic [FIDX_BITS-1:0]  w_fidx;
    logic [COUNT_BITS-1:0] w_c1, w_c0, w_f1, w_f0, w_g1, w_g0;
    logic [MAN_BITS+EXP_BITS:0] w_r1, w_r0;
    logic w_gt1, w_gt0, w_pred, w_correct;

    always_comb begin
        w_fidx = FIDX_BITS'(r_idx);
        w_x  = (32'(r_idx) < IN_BITS) ? r_feat[w_fidx] : 1'b0;
        w_c1 = r_cnt1[r_idx];
        w_c0 = r_cnt0[r_idx];
        w_f1 = w_x ? w_c1 : ((w_c1 <= r_n1) ? r_n1 - w_c1 : '0);
        w_f0 = w_x ? w_c0 : ((w_c0 <= r_n0) ? r_n0 - w_c0 : '0);
        w_g1 = r_phase ? r_n0 : w_f1;
        w_g0 = r_phase ? r_n1 : w_f0;
        w_r1 = pf_mul(r_z1, r_m1, r_e1, w_g1);
        w_r0 = pf_mul(r_z0, r_m0, r_e0, w_g0);
        w_gt1 = pf_gt(r_z1, r_m1, r_e1, r_z0, r_m0, r_e0);
        w_gt0 = pf_gt(r_z0, r_m0, r_e0, r_z1, r_m1, r_e1);
        w_pred = 1'b0;
        w_correct = 1'b0;
        if (r_n1 != '0 && r_n0 != '0) begin
            if (w_gt1) begin
                w_pred = 1'b1;
                w_correct = r_label;
            end else if (w_gt0) begin
                w_correct = !r_label;
            end
        end
    end

    // capture of the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_feat   <= i_features;
            r_label  <= i_label;
        end
    end

    // training counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1 <= '0;
            r_n0 <= '0;
            for (int j = 0; j < FEATURES; j++) begin
                r_cnt1[j] <= '0;
                r_cnt0[j] <= '0;
            end
        end else if (i_cmd.train) begin
            for (int j = 0; j < FEATURES; j++) begin
                if (j < IN_BITS && r_feat[j % IN_BITS]) begin
                    if (r_label && r_cnt1[j] != CNT_MAX)  r_cnt1[j] <= r_cnt1[j] + 1'b1;
                    if (!r_label && r_cnt0[j] != CNT_MAX) r_cnt0[j] <= r_cnt0[j] + 1'b1;
                end
            end
            if (r_label && r_n1 != CNT_MAX)  r_n1 <= r_n1 + 1'b1;
            if (!r_label && r_n0 != CNT_MAX) r_n0 <= r_n0 + 1'b1;
        end
    end

    // score accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.score_init) begin
            r_idx   <= '0;
            r_phase <= 1'b0;
            r_z1 <= (r_n1 == '0);
            r_z0 <= (r_n0 == '0);
            r_m1 <= MAN_BITS'(r_n1) << (MAN_BITS - COUNT_BITS);
            r_m0 <= MAN_BITS'(r_n0) << (MAN_BITS - COUNT_BITS);
            r_e1 <= EXP_BITS'(COUNT_BITS - 1);
            r_e0 <= EXP_BITS'(COUNT_BITS - 1);
            for (int k = 0; k < COUNT_BITS; k++) begin
                if (r_n1[k]) begin
                    r_m1 <= MAN_BITS'({r_n1, {MAN_BITS{1'b0}}} >> (k + 1));
                    r_e1 <= EXP_BITS'(k);
                end
                if (r_n0[k]) begin
                    r_m0 <= MAN_BITS'({r_n0, {MAN_BITS{1'b0}}} >> (k + 1));
                    r_e0 <= EXP_BITS'(k);
                end
            end
        end else if (i_cmd.score_step) begin
            {r_z1, r_m1, r_e1} <= w_r1;
            {r_z0, r_m0, r_e0} <= w_r0;
            r_phase <= !r_phase;
            if (r_phase) r_idx <= r_idx + 1'b1;
        end
    end

    // tallies and the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tal_c <= '0;
            r_tal_n <= '0;
            r_tal_1 <= '0;
        end else if (i_cmd.finish) begin
            r_pred    <= w_pred;
            r_correct <= w_correct;
            if (r_tal_n != TAL_MAX) r_tal_n <= r_tal_n + 1'b1;
            if (w_correct && r_tal_c != TAL_MAX) r_tal_c <= r_tal_c + 1'b1;
            if (w_pred && r_tal_1 != TAL_MAX)    r_tal_1 <= r_tal_1 + 1'b1;
        end
    end

    assign o_sts.is_classify  = (r_action == ACT_CLASSIFY);
    assign o_sts.last_feature = r_phase && (r_idx == LAST_IDX);
    assign o_pred             = r_pred;
    assign o_correct          = r_correct;
    assign o_correct_total    = r_tal_c;
    assign o_classified_total = r_tal_n;
    assign o_class_one_total  = r_tal_1;

endmodule

`default_nettype wire

// ===== tb/sv/bernoulli_naive_bayes_classifier_unit_test.sv =====
// ----------------------------------------------------------------------------
// bernoulli_naive_bayes_classifier_unit_test
// Self-checking bench: trains and classifies through the stream ports and
// compares every classify result with an in-bench scoring model.
// ----------------------------------------------------------------------------
`default_nettype none

module bernoulli_naive_bayes_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bnbc_pkg::*;

    localparam int unsigned NFEAT     = FEATURES_DEF;
    localparam int unsigned CMAX      = (1 << COUNT_BITS_DEF) - 1;
    localparam int unsigned TMAX      = 65535;
    localparam int unsigned EMAX      = 4095;
    localparam int unsigned N_RANDOM  = 1300;
    localparam longint      CYCLE_CAP = 2000000;

    typedef struct packed {
        logic [15:0] class_one_tot;
        logic [15:0] classified_tot;
        logic [15:0] correct_tot;
        logic        correct;
        logic        pred;
    } t_verdict;

    typedef struct {
        logic        action;
        logic [31:0] feats;
        logic        label;
        logic        typed;
        t_verdict    known;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;  // features[31:0]
    logic [1:0]                s_axis_tuser = '0;  // action, label
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;       // pred, correct, three totals, pad

    bernoulli_naive_bayes_classifier_unit dut (.*);

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state
    int unsigned cnt_one[NFEAT];
    int unsigned cnt_zero[NFEAT];
    int unsigned n_one, n_zero, tal_correct, tal_class, tal_one;
    t_verdict    pending_verdicts[$];
    int          errors = 0;
    int          src_idle = 23, snk_idle = 51;
    bit          snk_hold = 0;
    longint      cycles = 0;

    function automatic int unsigned sat(int unsigned v, int unsigned m);
        return (v < m) ? v + 1 : m;
    endfunction

    // pseudo-float multiply
    function automatic void pf_mul(inout bit z, inout logic [31:0] man,
                                   inout int unsigned ex, input int unsigned f);
        logic [63:0] p;
        if (z) return;
        if (f == 0) begin
            z = 1;
            return;
        end
        p = {32'b0, man} * 64'(f);
        while (p[63:32] != 0) begin
            p = p >> 1;
            ex++;
        end
        man = p[31:0];
        if (ex > EMAX) ex = EMAX;
    endfunction

    function automatic void class_score(input int unsigned own, input int unsigned other,
                                        input bit one, input logic [31:0] x,
                                        output bit z, output logic [31:0] man,
                                        output int unsigned ex);
        int unsigned c, f;
        z = 0;
        man = 32'h8000_0000;
        ex = 0;
        pf_mul(z, man, ex, own);
        for (int j = 0; j < NFEAT; j++) begin
            c = one ? cnt_one[j] : cnt_zero[j];
            if (x[j]) f = c;
            else f = (c <= own) ? own - c : 0;
            pf_mul(z, man, ex, f);
            pf_mul(z, man, ex, other);
        end
    endfunction

    function automatic bit pf_above(bit az, logic [31:0] am, int unsigned ae,
                                    bit bz, logic [31:0] bm, int unsigned be);
        if (az) return 0;
        if (bz) return 1;
        if (ae != be) return ae > be;
        return am > bm;
    endfunction

    // advance the model by one accepted transaction
    function automatic void predict_verdict(logic action, logic [31:0] x, logic label);
        bit z1, z0, pred, ok;
        logic [31:0] m1, m0;
        int unsigned e1, e0;
        t_verdict v;
        pred = 0;
        ok = 0;
        if (action == ACT_TRAIN) begin
            for (int j = 0; j < NFEAT; j++)
                if (x[j]) begin
                    if (label) cnt_one[j] = sat(cnt_one[j], CMAX);
                    else cnt_zero[j] = sat(cnt_zero[j], CMAX);
                end
            if (label) n_one = sat(n_one, CMAX);
            else n_zero = sat(n_zero, CMAX);
            return;
        end
        if (n_one != 0 && n_zero != 0) begin
            class_score(n_one, n_zero, 1, x, z1, m1, e1);
            class_score(n_zero, n_one, 0, x, z0, m0, e0);
            if (pf_above(z1, m1, e1, z0, m0, e0)) begin
                pred = 1;
                ok = label;
            end else if (pf_above(z0, m0, e0, z1, m1, e1)) begin
                ok = !label;
            end
        end
        tal_class = sat(tal_class, TMAX);
        if (ok) tal_correct = sat(tal_correct, TMAX);
        if (pred) tal_one = sat(tal_one, TMAX);
        v.pred = pred;
        v.correct = ok;
        v.correct_tot = tal_correct[15:0];
        v.classified_tot = tal_class[15:0];
        v.class_one_tot = tal_one[15:0];
        pending_verdicts = {pending_verdicts, v};
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // send one transaction, idling per the current rate
    task automatic send_item(logic action, logic [31:0] x, logic label);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= {label, action};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_verdict(action, x, label);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // receiver ready
    always @(posedge i_clk) begin
        m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_idle);
    end

    // result checking
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_verdict'(m_axis_tdata[49:0]);
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.pred != want.pred) report_mismatch("pred", got.pred, want.pred);
                if (got.correct != want.correct)
                    report_mismatch("correct", got.correct, want.correct);
                if (got.correct_tot != want.correct_tot)
                    report_mismatch("correct_total", got.correct_tot, want.correct_tot);
                if (got.classified_tot != want.classified_tot)
                    report_mismatch("classified_total", got.classified_tot,
                                    want.classified_tot);
                if (got.class_one_tot != want.class_one_tot)
                    report_mismatch("class_one_total", got.class_one_tot,
                                    want.class_one_tot);
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // long receiver hold-off
    initial begin
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        snk_hold = 1;
        repeat (1500) @(posedge i_clk);
        snk_hold = 0;
    end

    function automatic t_row mk(logic a, logic [31:0] x, logic l, logic t = 0,
                                t_verdict k = '0);
        t_row r;
        r.action = a;
        r.feats = x;
        r.label = l;
        r.typed = t;
        r.known = k;
        return r;
    endfunction

    // stimulus
    initial begin
        t_row        rows[$];
        logic [31:0] proto1, proto0, x;
        logic        lab;
        int          n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // untrained classes give class 0
        rows = {rows, mk(ACT_CLASSIFY, 32'h0, 1'b0, 1,
                         '{16'd0, 16'd1, 16'd0, 1'b0, 1'b0})};
        rows = {rows, mk(ACT_CLASSIFY, 32'hFFFF_FFFF, 1'b1, 1,
                         '{16'd0, 16'd2, 16'd0, 1'b0, 1'b0})};
        rows = {rows, mk(ACT_TRAIN, 32'hFFFF_FFFF, 1'b1)};
        // one class trained only
        rows = {rows, mk(ACT_CLASSIFY, 32'hFFFF_FFFF, 1'b1, 1,
                         '{16'd0, 16'd3, 16'd0, 1'b0, 1'b0})};
        rows = {rows, mk(ACT_TRAIN, 32'h0000_0000, 1'b0)};
        rows = {rows, mk(ACT_CLASSIFY, 32'hFFFF_FFFF, 1'b1)};
        rows = {rows, mk(ACT_CLASSIFY, 32'h0000_0000, 1'b0)};
        // symmetric training gives equal scores
        rows = {rows, mk(ACT_TRAIN, 32'h0000_0000, 1'b1)};
        rows = {rows, mk(ACT_TRAIN, 32'hFFFF_FFFF, 1'b0)};
        rows = {rows, mk(ACT_CLASSIFY, 32'h5555_AAAA, 1'b0)};
        rows = {rows, mk(ACT_TRAIN, 32'hF0F0_F0F0, 1'b1)};
        rows = {rows, mk(ACT_TRAIN, 32'h0F0F_0F0F, 1'b0)};
        rows = {rows, mk(ACT_TRAIN, 32'h8000_0001, 1'b1)};
        rows = {rows, mk(ACT_CLASSIFY, 32'hF0F0_F0F0, 1'b1)};
        rows = {rows, mk(ACT_CLASSIFY, 32'h0F0F_0F0F, 1'b0)};
        rows = {rows, mk(ACT_CLASSIFY, 32'h8000_0001, 1'b0)};
        rows = {rows, mk(ACT_CLASSIFY, 32'h1234_5678, 1'b1)};
        foreach (rows[i]) begin
            send_item(rows[i].action, rows[i].feats, rows[i].label);
            if (rows[i].typed) begin
                if (pending_verdicts.size() == 0 ||
                    pending_verdicts[$] != rows[i].known)
                    report_mismatch("directed row", i, 0);
            end
        end

        // random: mostly noisy prototypes, some pure noise
        proto1 = $urandom();
        proto0 = $urandom();
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 23 : (ph == 1) ? 51 : 0;
            snk_idle = (ph == 0) ? 51 : (ph == 1) ? 23 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) begin
                lab = $urandom_range(1);
                n = $urandom_range(9);
                if (n == 0) x = $urandom();
                else x = (lab ? proto1 : proto0) ^ ($urandom() & $urandom() & $urandom());
                send_item(($urandom_range(99) < 45) ? ACT_CLASSIFY : ACT_TRAIN, x, lab);
            end
            drain();
        end

        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
